// ===== sv/wpsh_pkg.sv =====
`default_nettype none

package wpsh_pkg;

    // Default geometry of the store
    localparam int SEPARATION_BINS_DEF = 32;
    localparam int MU_BINS_DEF         = 30;

    // Widest store index over the parameter range (256 * 64 entries)
    localparam int HIST_IDX_W = 14;

    // Register reset values
    localparam logic [31:0] MIN_SEP_RST   = 32'd0;
    localparam logic [31:0] MAX_SEP_RST   = 32'd13107200;
    localparam logic [31:0] BIN_WIDTH_RST = 32'd655360;
    localparam logic [5:0]  BINS_USED_RST = 6'd20;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_SPARE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_COUNTED = 2'd0,
        ST_DROPPED = 2'd1,
        ST_VALUE   = 2'd2,
        ST_CLEARED = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CFG_MIN_SEP   = 2'd0,
        CFG_MAX_SEP   = 2'd1,
        CFG_BIN_WIDTH = 2'd2,
        CFG_BINS_USED = 2'd3
    } cfg_idx_t;

    // Work handed from the front to the back
    typedef enum logic [2:0] {
        K_ADD,
        K_READ,
        K_READ_NONE,
        K_CLEAR,
        K_DROP
    } kind_t;

    typedef struct packed {
        kind_t                 kind;
        logic [HIST_IDX_W-1:0] index;
        logic [31:0]           weight;
    } job_t;

    typedef enum logic [3:0] {
        F_IDLE,
        F_DIFF,
        F_SQ,
        F_ROOT_START,
        F_ROOT,
        F_CHECK,
        F_RBIN,
        F_MU,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_INIT,
        B_IDLE,
        B_FETCH,
        B_CLEAR,
        B_DONE
    } back_state_t;

endpackage

`default_nettype wire

// ===== sv/wpsh_sqrt.sv =====
`default_nettype none

// Integer square root of a 66-bit value, one result bit per cycle
module wpsh_sqrt (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [65:0] radicand,
    output logic             done,
    output logic [32:0]      root
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [65:0] rad_reg, rad_next;
    logic [35:0] rem_reg, rem_next;
    logic [32:0] root_reg, root_next;
    logic [35:0] rem_shift;
    logic [35:0] trial;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    // Bring down two bits and try the next root bit
    always_comb
    begin
        rem_shift = {rem_reg[33:0], rad_reg[65:64]};
        trial     = {1'b0, root_reg, 2'b01};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (!busy_reg)
        begin
            if (start)
            begin
                busy_next = 1'b1;
                cnt_next  = 6'd32;
                rad_next  = radicand;
                rem_next  = '0;
                root_next = '0;
            end
        end
        else
        begin
            rad_next = {rad_reg[63:0], 2'b00};
            if (rem_shift >= trial)
            begin
                rem_next  = rem_shift - trial;
                root_next = {root_reg[31:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_shift;
                root_next = {root_reg[31:0], 1'b0};
            end
            if (cnt_reg == 6'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 6'd1;
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

// ===== sv/wpsh_div.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle
module wpsh_div #(
    parameter int NUM_W = 37
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] dividend,
    input  wire logic [31:0]      divisor,
    output logic                  done,
    output logic [NUM_W-1:0]      quotient
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [31:0]      den_reg, den_next;
    logic [31:0]      rem_reg, rem_next;
    logic [32:0]      part;
    logic [32:0]      diff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    // Shift in one dividend bit, subtract where it fits
    always_comb
    begin
        part      = {rem_reg, num_reg[NUM_W-1]};
        diff      = part - {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        if (!busy_reg)
        begin
            if (start)
            begin
                busy_next = 1'b1;
                cnt_next  = CNT_W'(NUM_W - 1);
                num_next  = dividend;
                den_next  = divisor;
                rem_next  = '0;
                quo_next  = '0;
            end
        end
        else
        begin
            num_next = num_reg << 1;
            if (part >= {1'b0, den_reg})
            begin
                rem_next = diff[31:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = part[31:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - CNT_W'(1);
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== sv/wpsh_queue.sv =====
`default_nettype none

// Two-entry queue between front and back
module wpsh_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire wpsh_pkg::job_t  push_job,
    output logic                 full,
    input  wire logic            pop,
    output logic                 head_valid,
    output wpsh_pkg::job_t       head_job
);

    wpsh_pkg::job_t slot_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    // Advance pointers
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_job   = slot_reg[rd_ptr_reg];

    assert property (@(posedge clk) disable iff (!rst_n) pop |-> count_reg != 2'd0)
        else $error("queue popped while empty");
    assert property (@(posedge clk) disable iff (!rst_n) push |-> (count_reg != 2'd2 || pop))
        else $error("queue pushed while full");
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree when empty");

endmodule

`default_nettype wire

// ===== sv/wpsh_front.sv =====
`default_nettype none

// Accept transactions, hold configuration, work out the bin of each pair
module wpsh_front #(
    parameter int SEPARATION_BINS = wpsh_pkg::SEPARATION_BINS_DEF,
    parameter int MU_BINS         = wpsh_pkg::MU_BINS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  operation,
    input  wire logic [31:0] first_x,
    input  wire logic [31:0] first_y,
    input  wire logic [31:0] first_z,
    input  wire logic [31:0] first_distance,
    input  wire logic [15:0] first_weight,
    input  wire logic [31:0] second_x,
    input  wire logic [31:0] second_y,
    input  wire logic [31:0] second_z,
    input  wire logic [31:0] second_distance,
    input  wire logic [15:0] second_weight,
    input  wire logic [9:0]  read_index,
    input  wire logic        back_init,
    output logic             push,
    output wpsh_pkg::job_t   push_job,
    input  wire logic        queue_full
);

    localparam int DEPTH  = SEPARATION_BINS * MU_BINS;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RBIN_W = (SEPARATION_BINS > 1) ? $clog2(SEPARATION_BINS) : 1;
    localparam int MU_W   = (MU_BINS > 1) ? $clog2(MU_BINS) : 1;
    localparam int NUM_W  = 32 + $clog2(MU_BINS + 1);
    localparam logic [NUM_W-1:0] MU_K     = NUM_W'(MU_BINS);
    localparam logic [NUM_W-1:0] MU_LAST  = NUM_W'(MU_BINS - 1);
    localparam logic [8:0]       SB_K     = 9'(SEPARATION_BINS);
    localparam logic [31:0]      DEPTH_K  = 32'(DEPTH);

    // Configuration registers
    logic [31:0] min_sep_reg;
    logic [31:0] max_sep_reg;
    logic [31:0] bin_width_reg;
    logic [5:0]  bins_used_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_sep_reg   <= wpsh_pkg::MIN_SEP_RST;
            max_sep_reg   <= wpsh_pkg::MAX_SEP_RST;
            bin_width_reg <= wpsh_pkg::BIN_WIDTH_RST;
            bins_used_reg <= wpsh_pkg::BINS_USED_RST;
        end
        else if (cfg_write)
        begin
            case (wpsh_pkg::cfg_idx_t'(cfg_index))
                wpsh_pkg::CFG_MIN_SEP:   min_sep_reg   <= cfg_data;
                wpsh_pkg::CFG_MAX_SEP:   max_sep_reg   <= cfg_data;
                wpsh_pkg::CFG_BIN_WIDTH: bin_width_reg <= cfg_data;
                wpsh_pkg::CFG_BINS_USED: bins_used_reg <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    wpsh_pkg::front_state_t state_reg, state_next;
    logic [1:0]  k_reg, k_next;

    logic [31:0] ax_reg, ay_reg, az_reg, ad_reg;
    logic [31:0] bx_reg, by_reg, bz_reg, bd_reg;
    logic [31:0] wprod_reg;
    logic [31:0] dx_reg, dy_reg, dz_reg, ddc_reg;
    logic [31:0] dx_next, dy_next, dz_next, ddc_next;
    logic [63:0] sq_reg, sq_next;
    logic [65:0] acc_reg, acc_next;
    logic [32:0] sep_reg, sep_next;
    logic [RBIN_W-1:0] rbin_reg, rbin_next;
    wpsh_pkg::job_t job_reg, job_next;

    logic             accept;
    logic             root_start, root_done;
    logic [32:0]      root;
    logic             div_start, div_done;
    logic [NUM_W-1:0] div_num;
    logic [31:0]      div_den;
    logic [NUM_W-1:0] quotient;
    logic [31:0]      dsel;
    logic [32:0]      ex, ey, ez;
    logic [8:0]       limit;
    logic [MU_W-1:0]  mubin;
    logic [IDX_W-1:0] idx;
    logic [31:0]      sep_off;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wpsh_pkg::F_IDLE;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

    // Capture the pair on acceptance
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ax_reg    <= first_x;
            ay_reg    <= first_y;
            az_reg    <= first_z;
            ad_reg    <= first_distance;
            bx_reg    <= second_x;
            by_reg    <= second_y;
            bz_reg    <= second_z;
            bd_reg    <= second_distance;
            wprod_reg <= 32'(first_weight) * 32'(second_weight);
        end
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        dz_reg   <= dz_next;
        ddc_reg  <= ddc_next;
        sq_reg   <= sq_next;
        acc_reg  <= acc_next;
        sep_reg  <= sep_next;
        rbin_reg <= rbin_next;
        job_reg  <= job_next;
    end

    wpsh_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand (acc_reg),
        .done     (root_done),
        .root     (root)
    );

    wpsh_div #(.NUM_W(NUM_W)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .done     (div_done),
        .quotient (quotient)
    );

    // Shared divider operands: separation bin first, then mu bin
    assign sep_off = sep_reg[31:0] - min_sep_reg;
    always_comb
    begin
        if (state_reg == wpsh_pkg::F_CHECK)
        begin
            div_num = NUM_W'(sep_off);
            div_den = bin_width_reg;
        end
        else
        begin
            div_num = NUM_W'(ddc_reg) * MU_K;
            div_den = sep_reg[31:0];
        end
    end

    assign accept = in_valid && !in_stall;
    assign in_stall = (state_reg != wpsh_pkg::F_IDLE) || back_init;
    assign limit = ({3'b000, bins_used_reg} < SB_K) ? {3'b000, bins_used_reg} : SB_K;
    assign ex = {ax_reg[31], ax_reg} - {bx_reg[31], bx_reg};
    assign ey = {ay_reg[31], ay_reg} - {by_reg[31], by_reg};
    assign ez = {az_reg[31], az_reg} - {bz_reg[31], bz_reg};
    assign mubin = (quotient >= MU_K) ? MU_LAST[MU_W-1:0] : quotient[MU_W-1:0];
    assign idx = IDX_W'(rbin_reg) * IDX_W'(MU_BINS) + IDX_W'(mubin);

    always_comb
    begin
        case (k_reg)
            2'd0:    dsel = dx_reg;
            2'd1:    dsel = dy_reg;
            default: dsel = dz_reg;
        endcase
    end

    // Sequence one transaction
    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        dz_next    = dz_reg;
        ddc_next   = ddc_reg;
        sq_next    = sq_reg;
        acc_next   = acc_reg;
        sep_next   = sep_reg;
        rbin_next  = rbin_reg;
        job_next   = job_reg;
        root_start = 1'b0;
        div_start  = 1'b0;
        push       = 1'b0;
        case (state_reg)
            wpsh_pkg::F_IDLE:
            begin
                if (accept)
                begin
                    job_next.index  = '0;
                    job_next.weight = '0;
                    case (wpsh_pkg::op_t'(operation))
                        wpsh_pkg::OP_ADD:
                        begin
                            job_next.kind = wpsh_pkg::K_DROP;
                            state_next    = wpsh_pkg::F_DIFF;
                        end
                        wpsh_pkg::OP_READ:
                        begin
                            job_next.kind  = (32'(read_index) < DEPTH_K) ?
                                             wpsh_pkg::K_READ : wpsh_pkg::K_READ_NONE;
                            job_next.index = wpsh_pkg::HIST_IDX_W'(read_index);
                            state_next     = wpsh_pkg::F_PUSH;
                        end
                        wpsh_pkg::OP_CLEAR:
                        begin
                            job_next.kind = wpsh_pkg::K_CLEAR;
                            state_next    = wpsh_pkg::F_PUSH;
                        end
                        default:
                        begin
                            job_next.kind = wpsh_pkg::K_DROP;
                            state_next    = wpsh_pkg::F_PUSH;
                        end
                    endcase
                end
            end
            wpsh_pkg::F_DIFF:
            begin
                dx_next    = ex[32] ? 32'(-ex) : ex[31:0];
                dy_next    = ey[32] ? 32'(-ey) : ey[31:0];
                dz_next    = ez[32] ? 32'(-ez) : ez[31:0];
                ddc_next   = (ad_reg > bd_reg) ? ad_reg - bd_reg : bd_reg - ad_reg;
                acc_next   = '0;
                k_next     = '0;
                state_next = wpsh_pkg::F_SQ;
            end
            wpsh_pkg::F_SQ:
            begin
                // Square one component while adding the previous one
                sq_next = dsel * dsel;
                if (k_reg != 2'd0)
                begin
                    acc_next = acc_reg + {2'b00, sq_reg};
                end
                k_next = k_reg + 2'd1;
                if (k_reg == 2'd3)
                begin
                    state_next = wpsh_pkg::F_ROOT_START;
                end
            end
            wpsh_pkg::F_ROOT_START:
            begin
                root_start = 1'b1;
                state_next = wpsh_pkg::F_ROOT;
            end
            wpsh_pkg::F_ROOT:
            begin
                if (root_done)
                begin
                    sep_next   = root;
                    state_next = wpsh_pkg::F_CHECK;
                end
            end
            wpsh_pkg::F_CHECK:
            begin
                if (sep_reg == '0 || sep_reg > {1'b0, max_sep_reg} ||
                    sep_reg < {1'b0, min_sep_reg} || bin_width_reg == '0)
                begin
                    state_next = wpsh_pkg::F_PUSH;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = wpsh_pkg::F_RBIN;
                end
            end
            wpsh_pkg::F_RBIN:
            begin
                if (div_done)
                begin
                    if (quotient >= NUM_W'(limit))
                    begin
                        state_next = wpsh_pkg::F_PUSH;
                    end
                    else
                    begin
                        rbin_next  = quotient[RBIN_W-1:0];
                        div_start  = 1'b1;
                        state_next = wpsh_pkg::F_MU;
                    end
                end
            end
            wpsh_pkg::F_MU:
            begin
                if (div_done)
                begin
                    job_next.kind   = wpsh_pkg::K_ADD;
                    job_next.index  = wpsh_pkg::HIST_IDX_W'(idx);
                    job_next.weight = wprod_reg;
                    state_next      = wpsh_pkg::F_PUSH;
                end
            end
            wpsh_pkg::F_PUSH:
            begin
                if (!queue_full)
                begin
                    push       = 1'b1;
                    state_next = wpsh_pkg::F_IDLE;
                end
            end
            default:
            begin
                state_next = wpsh_pkg::F_IDLE;
            end
        endcase
    end

    assign push_job = job_reg;

endmodule

`default_nettype wire

// ===== sv/wpsh_back.sv =====
`default_nettype none

// Own the histogram store: add, read, clear, and drive results
module wpsh_back #(
    parameter int SEPARATION_BINS = wpsh_pkg::SEPARATION_BINS_DEF,
    parameter int MU_BINS         = wpsh_pkg::MU_BINS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        head_valid,
    input  wire wpsh_pkg::job_t head_job,
    output logic             pop,
    output logic             init_busy,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       status,
    output logic [63:0]      bin_value
);

    localparam int DEPTH = SEPARATION_BINS * MU_BINS;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [IDX_W-1:0] LAST   = IDX_W'(DEPTH - 1);
    localparam logic [63:0]      ALL64  = {64{1'b1}};
    localparam logic [63:0]      SAT_LIM = ALL64 / 64'(MU_BINS);

    logic [63:0] mem [DEPTH];

    wpsh_pkg::back_state_t state_reg, state_next;
    logic [IDX_W-1:0] sweep_reg, sweep_next;
    logic             out_valid_reg, out_valid_next;
    logic [1:0]       out_status_reg, out_status_next;
    logic [63:0]      out_value_reg, out_value_next;
    wpsh_pkg::job_t   cur_reg, cur_next;
    logic [63:0]      res_reg, res_next;
    logic [63:0]      rdata_reg;

    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [63:0]      wdata;
    logic [IDX_W-1:0] raddr;
    logic [64:0]      sum;
    logic             out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wpsh_pkg::B_INIT;
            sweep_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg        <= cur_next;
        res_reg        <= res_next;
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
    end

    // Store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign raddr    = head_job.index[IDX_W-1:0];
    assign sum      = {1'b0, rdata_reg} + {33'd0, cur_reg.weight};
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next      = state_reg;
        sweep_next      = sweep_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        cur_next        = cur_reg;
        res_next        = res_reg;
        we              = 1'b0;
        waddr           = sweep_reg;
        wdata           = '0;
        pop             = 1'b0;
        case (state_reg)
            wpsh_pkg::B_INIT, wpsh_pkg::B_CLEAR:
            begin
                // Sweep zeros through the store
                we = 1'b1;
                if (sweep_reg == LAST)
                begin
                    sweep_next = '0;
                    state_next = (state_reg == wpsh_pkg::B_INIT) ?
                                 wpsh_pkg::B_IDLE : wpsh_pkg::B_DONE;
                end
                else
                begin
                    sweep_next = sweep_reg + IDX_W'(1);
                end
            end
            wpsh_pkg::B_IDLE:
            begin
                if (head_valid)
                begin
                    pop      = 1'b1;
                    cur_next = head_job;
                    res_next = '0;
                    case (head_job.kind)
                        wpsh_pkg::K_ADD, wpsh_pkg::K_READ:
                            state_next = wpsh_pkg::B_FETCH;
                        wpsh_pkg::K_CLEAR:
                        begin
                            sweep_next = '0;
                            state_next = wpsh_pkg::B_CLEAR;
                        end
                        default:
                            state_next = wpsh_pkg::B_DONE;
                    endcase
                end
            end
            wpsh_pkg::B_FETCH:
            begin
                if (cur_reg.kind == wpsh_pkg::K_ADD)
                begin
                    // Saturating accumulate
                    we    = 1'b1;
                    waddr = cur_reg.index[IDX_W-1:0];
                    wdata = sum[64] ? ALL64 : sum[63:0];
                end
                else
                begin
                    res_next = (rdata_reg > SAT_LIM) ? ALL64 : rdata_reg * 64'(MU_BINS);
                end
                state_next = wpsh_pkg::B_DONE;
            end
            wpsh_pkg::B_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = res_reg;
                    case (cur_reg.kind)
                        wpsh_pkg::K_ADD:       out_status_next = wpsh_pkg::ST_COUNTED;
                        wpsh_pkg::K_READ,
                        wpsh_pkg::K_READ_NONE: out_status_next = wpsh_pkg::ST_VALUE;
                        wpsh_pkg::K_CLEAR:     out_status_next = wpsh_pkg::ST_CLEARED;
                        default:               out_status_next = wpsh_pkg::ST_DROPPED;
                    endcase
                    state_next = wpsh_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = wpsh_pkg::B_IDLE;
            end
        endcase
    end

    assign init_busy = (state_reg == wpsh_pkg::B_INIT);
    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign bin_value = out_value_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == wpsh_pkg::B_INIT) |-> !out_valid_reg)
        else $error("result shown during start-up clear");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_status_reg != wpsh_pkg::ST_VALUE) |-> out_value_reg == '0)
        else $error("non-read result carries a value");
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (state_reg != wpsh_pkg::B_IDLE))
        else $error("popped job not taken into work");

endmodule

`default_nettype wire

// ===== sv/weighted_pair_separation_histogram_unit.sv =====
`default_nettype none

// Channel   Handshake            Payload
// in        in_valid / in_stall  operation, first_*, second_*, read_index
// out       out_valid/out_stall  status, bin_value
// config    cfg_write            cfg_index, cfg_data (no handshake back)
//
// An add runs through the bit-serial square root (33 steps)
// and two passes through the shared divider (one quotient bit per cycle).
// A clear writes one store entry per cycle through the single write port.
// After reset the store is swept to zero, SEPARATION_BINS*MU_BINS entries
// (960 by default), with in_stall held high.
// A stalled result holds in the output register; the queue lets the front
// carry on with the next transaction meanwhile.
module weighted_pair_separation_histogram_unit #(
    parameter int SEPARATION_BINS = wpsh_pkg::SEPARATION_BINS_DEF,
    parameter int MU_BINS         = wpsh_pkg::MU_BINS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  operation,
    input  wire logic [31:0] first_x,
    input  wire logic [31:0] first_y,
    input  wire logic [31:0] first_z,
    input  wire logic [31:0] first_distance,
    input  wire logic [15:0] first_weight,
    input  wire logic [31:0] second_x,
    input  wire logic [31:0] second_y,
    input  wire logic [31:0] second_z,
    input  wire logic [31:0] second_distance,
    input  wire logic [15:0] second_weight,
    input  wire logic [9:0]  read_index,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       status,
    output logic [63:0]      bin_value
);

    logic           push, pop, queue_full, head_valid, back_init;
    wpsh_pkg::job_t push_job, head_job;

    wpsh_front #(
        .SEPARATION_BINS (SEPARATION_BINS),
        .MU_BINS         (MU_BINS)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .operation       (operation),
        .first_x         (first_x),
        .first_y         (first_y),
        .first_z         (first_z),
        .first_distance  (first_distance),
        .first_weight    (first_weight),
        .second_x        (second_x),
        .second_y        (second_y),
        .second_z        (second_z),
        .second_distance (second_distance),
        .second_weight   (second_weight),
        .read_index      (read_index),
        .back_init       (back_init),
        .push            (push),
        .push_job        (push_job),
        .queue_full      (queue_full)
    );

    wpsh_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    wpsh_back #(
        .SEPARATION_BINS (SEPARATION_BINS),
        .MU_BINS         (MU_BINS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .init_busy  (back_init),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .bin_value  (bin_value)
    );

endmodule

`default_nettype wire
